// ----- rtl/core/cmmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmt_pkg
// Shared types and constants for the channel min/max tracker.
// ----------------------------------------------------------------------------
package cmmt_pkg;

    // default parameter values
    localparam int Channels     = 48;
    localparam int FrameSamples = 16;
    localparam int SampleBits   = 12;

    // fixed field widths
    localparam int ChanW     = 6;
    localparam int IndexW    = 4;
    localparam int ValueW    = 16;
    localparam int MarkW     = 13;
    localparam int GainEnW   = 2;
    localparam int ChanEnW   = 48;
    localparam int WinW      = 5;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 48;

    // register reset values
    localparam logic [GainEnW-1:0] GainEnReset   = 2'b11;
    localparam logic [ChanEnW-1:0] ChanEnReset   = '1;
    localparam logic [WinW-1:0]    WinStartReset = 5'd0;
    localparam logic [WinW-1:0]    WinEndReset   = 5'd16;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_GAIN_ENABLE    = 2'd0,
        CFG_CHANNEL_ENABLE = 2'd1,
        CFG_WINDOW_START   = 2'd2,
        CFG_WINDOW_END     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;     // capture item, issue store read
        logic update;   // compare, write back, emit result
    } t_dp_cmd;

endpackage

// ----- rtl/core/channel_min_max_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_min_max_tracker
// Per-channel, per-gain minimum/maximum tracker for ADC samples.
// ----------------------------------------------------------------------------
//
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------
// item in  | start, accepted if !busy  | op, gain_select, channel,
//          |                           | sample_index, sample_value
// result   | o_result_valid, 1 cycle   | low_mark, high_mark, accepted
// config   | i_cfg_we, every edge      | i_cfg_index, i_cfg_data
//
// On each item the accept edge issues the store read, and the next cycle
// compares against the read data and writes the entry back. busy is high
// during that update cycle, so the store's single write port and its
// registered read hold off a new item until the update is done.
// The result strobes for one cycle after the update, overlapping the next
// accept; the receiver cannot stall it.
// Reset clears the FSM, config registers and seen flags; the
// min/max stores hold garbage until written and are only read behind a set
// seen flag, so no clearing pass is needed. A clear op drops all flags at once.
// ----------------------------------------------------------------------------
module channel_min_max_tracker #(
    parameter int CHANNELS      = cmmt_pkg::Channels,
    parameter int FRAME_SAMPLES = cmmt_pkg::FrameSamples,
    parameter int SAMPLE_BITS   = cmmt_pkg::SampleBits
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic                                i_gain_select,
    input  logic [cmmt_pkg::ChanW-1:0]          i_channel,
    input  logic [cmmt_pkg::IndexW-1:0]         i_sample_index,
    input  logic signed [cmmt_pkg::ValueW-1:0]  i_sample_value,
    // result channel
    output logic                                o_result_valid,
    output logic signed [cmmt_pkg::MarkW-1:0]   o_low_mark,
    output logic signed [cmmt_pkg::MarkW-1:0]   o_high_mark,
    output logic                                o_accepted,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [cmmt_pkg::CfgIndexW-1:0]      i_cfg_index,
    input  logic [cmmt_pkg::CfgDataW-1:0]       i_cfg_data
);

    cmmt_pkg::t_dp_cmd w_cmd;

    // sequencer: load on accept, update on the following cycle
    cmmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // qualification, stores and result registers
    cmmt_dp #(
        .CHANNELS      (CHANNELS),
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_gain_select  (i_gain_select),
        .i_channel      (i_channel),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .o_result_valid (o_result_valid),
        .o_low_mark     (o_low_mark),
        .o_high_mark    (o_high_mark),
        .o_accepted     (o_accepted)
    );

endmodule

// ----- rtl/core/cmmt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmt_ctrl
// Sequencer: accept an item, then step through the update state.
// ----------------------------------------------------------------------------
module cmmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output cmmt_pkg::t_dp_cmd o_cmd
);

    cmmt_pkg::t_state r_state;
    cmmt_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmmt_pkg::S_IDLE: begin
                if (start) n_state = cmmt_pkg::S_UPDATE;
            end
            cmmt_pkg::S_UPDATE: begin
                n_state = cmmt_pkg::S_IDLE;
            end
            default: begin
                n_state = cmmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy         = (r_state != cmmt_pkg::S_IDLE);
    assign o_cmd.load   = start && (r_state == cmmt_pkg::S_IDLE);
    assign o_cmd.update = (r_state == cmmt_pkg::S_UPDATE);

endmodule

// ----- rtl/core/cmmt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmmt_dp
// Config registers, min/max stores, seen flags and result registers.
// ----------------------------------------------------------------------------
module cmmt_dp #(
    parameter int CHANNELS      = cmmt_pkg::Channels,
    parameter int FRAME_SAMPLES = cmmt_pkg::FrameSamples,
    parameter int SAMPLE_BITS   = cmmt_pkg::SampleBits
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cmmt_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_cfg_we,
    input  logic [cmmt_pkg::CfgIndexW-1:0]      i_cfg_index,
    input  logic [cmmt_pkg::CfgDataW-1:0]       i_cfg_data,
    input  logic                                i_op,
    input  logic                                i_gain_select,
    input  logic [cmmt_pkg::ChanW-1:0]          i_channel,
    input  logic [cmmt_pkg::IndexW-1:0]         i_sample_index,
    input  logic signed [cmmt_pkg::ValueW-1:0]  i_sample_value,
    output logic                                o_result_valid,
    output logic signed [cmmt_pkg::MarkW-1:0]   o_low_mark,
    output logic signed [cmmt_pkg::MarkW-1:0]   o_high_mark,
    output logic                                o_accepted
);

    localparam int Entries = 2 * CHANNELS;
    localparam int EntryW  = $clog2(Entries);
    localparam int CmpW    = 9;    // holds FRAME_SAMPLES up to 511
    localparam int ChCmpW  = cmmt_pkg::ChanW + 1;

    // config registers
    logic [cmmt_pkg::GainEnW-1:0] r_gain_en;
    logic [cmmt_pkg::ChanEnW-1:0] r_chan_en;
    logic [cmmt_pkg::WinW-1:0]    r_win_start;
    logic [cmmt_pkg::WinW-1:0]    r_win_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_en   <= cmmt_pkg::GainEnReset;
            r_chan_en   <= cmmt_pkg::ChanEnReset;
            r_win_start <= cmmt_pkg::WinStartReset;
            r_win_end   <= cmmt_pkg::WinEndReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cmmt_pkg::CFG_GAIN_ENABLE:
                    r_gain_en <= i_cfg_data[cmmt_pkg::GainEnW-1:0];
                cmmt_pkg::CFG_CHANNEL_ENABLE:
                    r_chan_en <= i_cfg_data[cmmt_pkg::ChanEnW-1:0];
                cmmt_pkg::CFG_WINDOW_START:
                    r_win_start <= i_cfg_data[cmmt_pkg::WinW-1:0];
                cmmt_pkg::CFG_WINDOW_END:
                    r_win_end <= i_cfg_data[cmmt_pkg::WinW-1:0];
                default: ;
            endcase
        end
    end

    // item qualification
    logic [cmmt_pkg::ValueW-1:0] w_raw;
    logic [63:0]                 w_chan_en_ext;
    logic                        w_valid;
    logic                        w_acc;
    logic [EntryW-1:0]           w_entry;

    assign w_raw         = i_sample_value;
    assign w_chan_en_ext = {{(64 - cmmt_pkg::ChanEnW){1'b0}}, r_chan_en};
    assign w_valid       = ChCmpW'(i_channel) < ChCmpW'(CHANNELS);

    always_comb begin
        w_acc = w_valid
             && r_gain_en[i_gain_select]
             && w_chan_en_ext[i_channel]
             && (cmmt_pkg::WinW'(i_sample_index) >= r_win_start)
             && (cmmt_pkg::WinW'(i_sample_index) < r_win_end)
             && (CmpW'(i_sample_index) < CmpW'(FRAME_SAMPLES))
             && !w_raw[cmmt_pkg::ValueW-1]
             && ((w_raw >> SAMPLE_BITS) == '0);
        if (!w_valid) begin
            w_entry = '0;
        end else if (i_gain_select) begin
            w_entry = EntryW'(i_channel) + EntryW'(CHANNELS);
        end else begin
            w_entry = EntryW'(i_channel);
        end
    end

    // captured item
    logic                   r_op;
    logic                   r_valid;
    logic                   r_acc;
    logic [EntryW-1:0]      r_entry;
    logic [SAMPLE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_valid <= w_valid;
            r_acc   <= w_acc && !i_op;
            r_entry <= w_entry;
            r_value <= w_raw[SAMPLE_BITS-1:0];
        end
    end

    // min/max stores, read on load, written on update
    logic [SAMPLE_BITS-1:0] r_min_mem [Entries];
    logic [SAMPLE_BITS-1:0] r_max_mem [Entries];
    logic [SAMPLE_BITS-1:0] r_rd_min;
    logic [SAMPLE_BITS-1:0] r_rd_max;
    logic [SAMPLE_BITS-1:0] n_min;
    logic [SAMPLE_BITS-1:0] n_max;
    logic                   w_seen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_min <= r_min_mem[w_entry];
            r_rd_max <= r_max_mem[w_entry];
        end
        if (i_cmd.update && r_acc) begin
            r_min_mem[r_entry] <= n_min;
            r_max_mem[r_entry] <= n_max;
        end
    end

    // seen flags clear at once on reset or a clear op
    logic [Entries-1:0] r_seen;

    assign w_seen = r_seen[r_entry];
    assign n_min  = (!w_seen || (r_value < r_rd_min)) ? r_value : r_rd_min;
    assign n_max  = (!w_seen || (r_value > r_rd_max)) ? r_value : r_rd_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.update) begin
            if (r_op) begin
                r_seen <= '0;
            end else if (r_acc) begin
                r_seen[r_entry] <= 1'b1;
            end
        end
    end

    // result registers
    logic signed [cmmt_pkg::MarkW-1:0] n_low;
    logic signed [cmmt_pkg::MarkW-1:0] n_high;

    always_comb begin
        if (r_op || !r_valid) begin
            n_low  = '1;
            n_high = '1;
        end else if (r_acc) begin
            n_low  = cmmt_pkg::MarkW'(n_min);
            n_high = cmmt_pkg::MarkW'(n_max);
        end else if (w_seen) begin
            n_low  = cmmt_pkg::MarkW'(r_rd_min);
            n_high = cmmt_pkg::MarkW'(r_rd_max);
        end else begin
            n_low  = '1;
            n_high = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_low_mark  <= n_low;
            o_high_mark <= n_high;
            o_accepted  <= r_acc;
        end
    end

`ifndef NO_ASSERTIONS
    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> o_result_valid)
        else $error("result strobe missing after update");

    a_accepted_marks_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_accepted) |->
            (o_low_mark >= 0 && o_low_mark <= o_high_mark))
        else $error("accepted result has bad marks");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_op) |=> (r_seen == '0))
        else $error("clear op left seen flags set");

    a_accept_marks_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_acc) |=> r_seen[$past(r_entry)])
        else $error("accepted item did not mark its entry");
`endif

endmodule

// ----- tb/tb_channel_min_max_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_min_max_tracker
// Self-checking bench for the per-channel, per-gain min/max tracker.
// Items are queued by a stimulus process and fed by a clocked driver with
// random gaps. Every item the block takes goes through a local tracker
// model; its marks are queued and compared field by field with each strobe.
// The config registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_channel_min_max_tracker;

    // item op codes and gain select values
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;
    localparam logic GAIN_LOW  = 1'b0;
    localparam logic GAIN_HIGH = 1'b1;

    // mark value of an entry that has taken nothing yet
    localparam logic signed [cmmt_pkg::MarkW-1:0] NO_MARK = -1;

    // gap styles for a phase: none, 0..16 on every item, or mostly back-to-back
    localparam int GAP_NONE  = 0;
    localparam int GAP_FULL  = 16;
    localparam int GAP_MIXED = -1;

    typedef struct {
        logic                               op;
        logic                               gain;
        logic [cmmt_pkg::ChanW-1:0]         channel;
        logic [cmmt_pkg::IndexW-1:0]        index;
        logic signed [cmmt_pkg::ValueW-1:0] value;
        int                                 gap;      // idle cycles before this item
    } t_sample_cmd;

    typedef struct {
        logic signed [cmmt_pkg::MarkW-1:0] low;
        logic signed [cmmt_pkg::MarkW-1:0] high;
        logic                              acc;
    } t_marks;

    // ---------------------------------------------------------------- DUT I/O
    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               start          = 1'b0;
    logic                               busy;
    logic                               i_op           = OP_SAMPLE;
    logic                               i_gain_select  = GAIN_LOW;
    logic [cmmt_pkg::ChanW-1:0]         i_channel      = '0;
    logic [cmmt_pkg::IndexW-1:0]        i_sample_index = '0;
    logic signed [cmmt_pkg::ValueW-1:0] i_sample_value = '0;
    logic                               o_result_valid;
    logic signed [cmmt_pkg::MarkW-1:0]  o_low_mark;
    logic signed [cmmt_pkg::MarkW-1:0]  o_high_mark;
    logic                               o_accepted;
    logic                               i_cfg_we       = 1'b0;
    cmmt_pkg::t_cfg_index               i_cfg_index    = cmmt_pkg::CFG_GAIN_ENABLE;
    logic [cmmt_pkg::CfgDataW-1:0]      i_cfg_data     = '0;

    channel_min_max_tracker DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_gain_select  (i_gain_select),
        .i_channel      (i_channel),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .o_result_valid (o_result_valid),
        .o_low_mark     (o_low_mark),
        .o_high_mark    (o_high_mark),
        .o_accepted     (o_accepted),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------- tracker model
    // Local copy of the config registers, reset values to start with.
    logic [cmmt_pkg::GainEnW-1:0] gain_on   = cmmt_pkg::GainEnReset;
    logic [cmmt_pkg::ChanEnW-1:0] chan_on   = cmmt_pkg::ChanEnReset;
    logic [cmmt_pkg::WinW-1:0]    win_start = cmmt_pkg::WinStartReset;
    logic [cmmt_pkg::WinW-1:0]    win_end   = cmmt_pkg::WinEndReset;

    // One entry per (gain, channel); low gain entries first.
    logic [cmmt_pkg::SampleBits-1:0] min_mark [2*cmmt_pkg::Channels];
    logic [cmmt_pkg::SampleBits-1:0] max_mark [2*cmmt_pkg::Channels];
    bit                              seen     [2*cmmt_pkg::Channels];

    t_sample_cmd pending_q [$];     // items waiting for the driver
    t_marks      mark_q    [$];     // marks expected from the block, oldest first
    t_sample_cmd cur_cmd;           // item now on the input ports
    int          idle_cycles = 0;
    int          fail_count  = 0;

    initial foreach (seen[e]) seen[e] = 1'b0;

    // Apply one item to the model and return the marks the block must report.
    function automatic t_marks track_sample(t_sample_cmd c);
        t_marks m;
        int     entry;
        bit     hit;
        m.low  = NO_MARK;
        m.high = NO_MARK;
        m.acc  = 1'b0;
        if (c.op == OP_CLEAR) begin
            foreach (seen[e]) seen[e] = 1'b0;
            return m;
        end
        // channels without an entry report nothing and touch nothing
        if (c.channel >= cmmt_pkg::Channels)
            return m;
        entry = c.gain * cmmt_pkg::Channels + c.channel;
        hit = gain_on[c.gain] && chan_on[c.channel]
              && c.index >= win_start && c.index < win_end
              && c.index < cmmt_pkg::FrameSamples
              && c.value >= 0 && c.value < (1 << cmmt_pkg::SampleBits);
        if (hit) begin
            if (!seen[entry]) begin
                min_mark[entry] = c.value[cmmt_pkg::SampleBits-1:0];
                max_mark[entry] = c.value[cmmt_pkg::SampleBits-1:0];
                seen[entry]     = 1'b1;
            end else begin
                if (c.value[cmmt_pkg::SampleBits-1:0] < min_mark[entry])
                    min_mark[entry] = c.value[cmmt_pkg::SampleBits-1:0];
                if (c.value[cmmt_pkg::SampleBits-1:0] > max_mark[entry])
                    max_mark[entry] = c.value[cmmt_pkg::SampleBits-1:0];
            end
        end
        // a rejected sample still reports the entry's current marks
        if (seen[entry]) begin
            m.low  = cmmt_pkg::MarkW'(min_mark[entry]);
            m.high = cmmt_pkg::MarkW'(max_mark[entry]);
        end
        m.acc = hit;
        return m;
    endfunction

    // ------------------------------------------------------------- clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------ driver
    // Put the next queued item on the ports and raise start.
    task automatic issue_next();
        cur_cmd = pending_q.pop_front();
        i_op           <= cur_cmd.op;
        i_gain_select  <= cur_cmd.gain;
        i_channel      <= cur_cmd.channel;
        i_sample_index <= cur_cmd.index;
        i_sample_value <= cur_cmd.value;
        start          <= 1'b1;
    endtask

    // start is held until the block takes the item (start high, busy low).
    // A zero-gap item follows straight on, keeping start high; otherwise
    // start drops and the driver counts out the item's gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            idle_cycles <= 0;
        end else if (start) begin
            if (!busy) begin
                mark_q.push_back(track_sample(cur_cmd));
                if (pending_q.size() != 0 && pending_q[0].gap == 0) begin
                    issue_next();
                end else begin
                    start       <= 1'b0;
                    idle_cycles <= 1;
                end
            end
        end else if (pending_q.size() != 0) begin
            if (idle_cycles >= pending_q[0].gap) begin
                issue_next();
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ----------------------------------------------------------- monitor
    // Results cannot be held off: every strobe is taken at the edge ending it.
    always @(posedge i_clk) begin : result_check
        t_marks want;
        if (i_rst_n && o_result_valid) begin
            if (mark_q.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: result with no item pending: low %0d high %0d acc %0b",
                             $realtime, o_low_mark, o_high_mark, o_accepted);
                fail_count++;
            end else begin
                want = mark_q.pop_front();
                if (o_low_mark !== want.low || o_high_mark !== want.high
                    || o_accepted !== want.acc) begin
                    if (fail_count < 10)
                        $display({"%0t: mismatch: expected low %0d high %0d acc %0b,",
                                  " got low %0d high %0d acc %0b"},
                                 $realtime, want.low, want.high, want.acc,
                                 o_low_mark, o_high_mark, o_accepted);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------- stimulus
    task automatic push_cmd(input logic op, input logic gain, input int channel,
                            input int index, input int value, input int gap);
        t_sample_cmd c;
        c.op      = op;
        c.gain    = gain;
        c.channel = cmmt_pkg::ChanW'(channel);
        c.index   = cmmt_pkg::IndexW'(index);
        c.value   = cmmt_pkg::ValueW'(value);
        c.gap     = gap;
        pending_q.push_back(c);
    endtask

    // Mostly well-formed samples on a few busy channels, inside the window,
    // with a share of clears, dead channels, out-of-range values and stray
    // indexes mixed in.
    function automatic t_sample_cmd rand_cmd(int gap_style);
        t_sample_cmd c;
        int          roll;
        roll      = $urandom_range(99);
        c.op      = OP_SAMPLE;
        c.gain    = $urandom_range(1);
        c.channel = $urandom_range(1)
                    ? cmmt_pkg::ChanW'($urandom_range(3))
                    : cmmt_pkg::ChanW'($urandom_range(cmmt_pkg::Channels - 1));
        c.index   = (win_start < win_end)
                    ? cmmt_pkg::IndexW'($urandom_range(win_end - 1, win_start))
                    : cmmt_pkg::IndexW'($urandom_range(15));
        c.value   = cmmt_pkg::ValueW'($urandom_range(4095));
        if (roll < 3)
            c.op = OP_CLEAR;
        else if (roll < 10)
            c.channel = cmmt_pkg::ChanW'($urandom_range(63, cmmt_pkg::Channels));
        else if (roll < 18)
            c.value = cmmt_pkg::ValueW'($urandom_range(65535, 4096));  // negative or too big
        else if (roll < 25)
            c.index = cmmt_pkg::IndexW'($urandom_range(15));
        else if (roll < 30)
            c.value = $urandom_range(1) ? cmmt_pkg::ValueW'(0) : cmmt_pkg::ValueW'(4095);
        if (gap_style == GAP_MIXED)
            c.gap = ($urandom_range(3) == 0) ? $urandom_range(GAP_FULL) : 0;
        else
            c.gap = $urandom_range(gap_style);
        return c;
    endfunction

    // Wait until every item has been taken and every result has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || start || busy || mark_q.size() != 0);
    endtask

    // Config writes go back to back; the model copy follows each write.
    task automatic write_reg(input cmmt_pkg::t_cfg_index idx,
                             input logic [cmmt_pkg::CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            cmmt_pkg::CFG_GAIN_ENABLE:    gain_on   = data[cmmt_pkg::GainEnW-1:0];
            cmmt_pkg::CFG_CHANNEL_ENABLE: chan_on   = data[cmmt_pkg::ChanEnW-1:0];
            cmmt_pkg::CFG_WINDOW_START:   win_start = data[cmmt_pkg::WinW-1:0];
            cmmt_pkg::CFG_WINDOW_END:     win_end   = data[cmmt_pkg::WinW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int gains, input logic [cmmt_pkg::ChanEnW-1:0] chans,
                              input int ws, input int we);
        write_reg(cmmt_pkg::CFG_GAIN_ENABLE, cmmt_pkg::CfgDataW'(gains));
        write_reg(cmmt_pkg::CFG_CHANNEL_ENABLE, chans);
        write_reg(cmmt_pkg::CFG_WINDOW_START, cmmt_pkg::CfgDataW'(ws));
        write_reg(cmmt_pkg::CFG_WINDOW_END, cmmt_pkg::CfgDataW'(we));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Queue a batch of random items (filled at the falling edge, away from
    // the driver) and let it drain.
    task automatic run_phase(input int count, input int gap_style);
        @(negedge i_clk);
        repeat (count) pending_q.push_back(rand_cmd(gap_style));
        wait_idle();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening under reset config
        push_cmd(OP_CLEAR,  GAIN_LOW,  0,  0, 0,      0);  // clear with nothing stored
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  0, 0,      0);  // first sample, lowest value
        push_cmd(OP_SAMPLE, GAIN_HIGH, 47, 15, 4095,  0);  // top channel, top index, top value
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  15, 4095,  1);  // raises the max
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  7,  2048,  0);  // inside the marks, no change
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  3,  -1,    0);  // negative, rejected
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  3,  4096,  2);  // just above range
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  3,  -32768, 0);
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  3,  32767, 0);
        push_cmd(OP_SAMPLE, GAIN_LOW,  48, 5,  100,   0);  // first channel with no entry
        push_cmd(OP_SAMPLE, GAIN_HIGH, 63, 5,  100,   1);  // highest channel code
        push_cmd(OP_SAMPLE, GAIN_HIGH, 47, 0,  1,     0);  // lowers the min
        push_cmd(OP_CLEAR,  GAIN_HIGH, 47, 0,  0,     0);
        push_cmd(OP_SAMPLE, GAIN_LOW,  0,  0,  -5,    0);  // rejected on a cleared entry
        push_cmd(OP_SAMPLE, GAIN_HIGH, 47, 8,  'h0AAA, 3);
        push_cmd(OP_SAMPLE, GAIN_LOW,  21, 10, 'h0555, 0);
        run_phase(90, GAP_MIXED);

        // low gain only, random channel mask, narrow window
        set_config(1, cmmt_pkg::ChanEnW'({$urandom, $urandom}), 4, 12);
        run_phase(60, GAP_FULL);

        // high gain only, empty window
        set_config(2, cmmt_pkg::ChanEnReset, 0, 0);
        run_phase(25, GAP_NONE);

        // everything off, window pinned at the frame end
        set_config(0, '0, 16, 16);
        run_phase(20, GAP_FULL);

        // reversed window
        set_config(3, cmmt_pkg::ChanEnReset, 10, 5);
        run_phase(20, GAP_NONE);

        // full window, random channel mask
        set_config(3, cmmt_pkg::ChanEnW'({$urandom, $urandom}), 0, 16);
        run_phase(100, GAP_MIXED);

        // only the last sample index
        set_config(3, cmmt_pkg::ChanEnReset, 15, 16);
        run_phase(40, GAP_FULL);

        // back to reset values
        set_config(cmmt_pkg::GainEnReset, cmmt_pkg::ChanEnReset,
                   cmmt_pkg::WinStartReset, cmmt_pkg::WinEndReset);
        run_phase(80, GAP_NONE);

        // keep clocking to catch any stray strobe
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && mark_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin : watchdog
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
